FILE: sv/assert_macros.svh
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("allocator assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

FILE: sv/bca_pkg.sv
// types, codes and helpers of the bitmap chunk allocator
`timescale 1ns / 1ps
package bca_pkg;
	localparam int MAX_BLOCKS_DEF = 16;
	localparam int CPB_MAX_DEF    = 256;

	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 25;
	localparam int CPB_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int BYTE_W     = 8;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_FREE    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;
	localparam logic [1:0] REQ_NEXT    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OOM      = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;
	localparam logic [1:0] ST_ITER_END = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_PER_BLOCK = 2'd3;

	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 25'd4096;
	localparam logic [SIZE_W-1:0] CHUNK_SIZE_RST = 25'd64;
	localparam logic [CPB_W-1:0]  CPB_RST        = 9'd64;

	// commands from the controller
	typedef struct packed {
		logic in_load;
		logic res_oom;
		logic res_bad;
		logic restart;
		logic a_init;
		logic rd_alloc;
		logic a_eval;
		logic clr_init;
		logic clr_step;
		logic div_load1;
		logic div_step;
		logic div_mid;
		logic f_chk;
		logic rd_free;
		logic f_eval;
		logic n_chk;
		logic rd_next;
		logic n_eval;
		logic mul;
		logic sum;
		logic out_load;
	} bca_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       n_zero;
		logic       biu_zero;
		logic       biu_full;
		logic       free_bad;
		logic       div_last;
		logic       a_hit;
		logic       a_last;
		logic       clr_last;
		logic       f_bad_blk;
		logic       f_skip;
		logic       n_end;
		logic       n_skip;
		logic       n_hit;
		logic       out_free;
	} bca_sts_t;

	// position of the lowest set bit of a byte
	function automatic logic [2:0] low_bit8(input logic [BYTE_W-1:0] v);
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				pos = 3'(i);
			end
		end
		return pos;
	endfunction
endpackage

FILE: sv/bca_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface bca_req_if import bca_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [ADDR_W-1:0] req_address;
	modport source(output valid, req_type, req_address, input ready);
	modport sink(input valid, req_type, req_address, output ready);
endinterface

interface bca_rsp_if import bca_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [ADDR_W-1:0] chunk_address;
	modport source(output valid, status, chunk_address, input ready);
	modport sink(input valid, status, chunk_address, output ready);
endinterface

FILE: sv/bca_ctrl.sv
// controller state machine of the allocator
`timescale 1ns / 1ps
module bca_ctrl import bca_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  bca_sts_t sts,
	output bca_cmd_t cmd
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_ARD  = 5'd2;
	localparam logic [4:0] S_AEV  = 5'd3;
	localparam logic [4:0] S_CLR  = 5'd4;
	localparam logic [4:0] S_DIV1 = 5'd5;
	localparam logic [4:0] S_DMID = 5'd6;
	localparam logic [4:0] S_DIV2 = 5'd7;
	localparam logic [4:0] S_FCHK = 5'd8;
	localparam logic [4:0] S_FRD  = 5'd9;
	localparam logic [4:0] S_FEV  = 5'd10;
	localparam logic [4:0] S_NCHK = 5'd11;
	localparam logic [4:0] S_NRD  = 5'd12;
	localparam logic [4:0] S_NEV  = 5'd13;
	localparam logic [4:0] S_MUL  = 5'd14;
	localparam logic [4:0] S_SUM  = 5'd15;
	localparam logic [4:0] S_DONE = 5'd16;

	logic [4:0] st_q;
	logic [4:0] st_nxt;

	always_comb begin
		cmd       = '0;
		st_nxt    = st_q;
		req_ready = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.in_load = 1'b1;
					st_nxt      = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.req_type)
					REQ_ALLOC: begin
						if (sts.n_zero) begin
							cmd.res_oom = 1'b1;
							st_nxt      = S_MUL;
						end else if (sts.biu_zero) begin
							cmd.clr_init = 1'b1;
							st_nxt       = S_CLR;
						end else begin
							cmd.a_init = 1'b1;
							st_nxt     = S_ARD;
						end
					end
					REQ_FREE: begin
						if (sts.free_bad) begin
							cmd.res_bad = 1'b1;
							st_nxt      = S_MUL;
						end else begin
							cmd.div_load1 = 1'b1;
							st_nxt        = S_DIV1;
						end
					end
					REQ_RESTART: begin
						cmd.restart = 1'b1;
						st_nxt      = S_MUL;
					end
					REQ_NEXT: begin
						st_nxt = S_NCHK;
					end
				endcase
			end
			S_ARD: begin
				cmd.rd_alloc = 1'b1;
				st_nxt       = S_AEV;
			end
			S_AEV: begin
				cmd.a_eval = 1'b1;
				if (sts.a_hit) begin
					st_nxt = S_MUL;
				end else if (sts.a_last) begin
					if (sts.biu_full) begin
						cmd.res_oom = 1'b1;
						st_nxt      = S_MUL;
					end else begin
						cmd.clr_init = 1'b1;
						st_nxt       = S_CLR;
					end
				end else begin
					st_nxt = S_ARD;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					st_nxt = S_MUL;
				end
			end
			S_DIV1: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					st_nxt = S_DMID;
				end
			end
			S_DMID: begin
				cmd.div_mid = 1'b1;
				st_nxt      = S_DIV2;
			end
			S_DIV2: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					st_nxt = S_FCHK;
				end
			end
			S_FCHK: begin
				cmd.f_chk = 1'b1;
				if (sts.f_bad_blk || sts.f_skip) begin
					st_nxt = S_MUL;
				end else begin
					st_nxt = S_FRD;
				end
			end
			S_FRD: begin
				cmd.rd_free = 1'b1;
				st_nxt      = S_FEV;
			end
			S_FEV: begin
				cmd.f_eval = 1'b1;
				st_nxt     = S_MUL;
			end
			S_NCHK: begin
				cmd.n_chk = 1'b1;
				if (sts.n_end) begin
					st_nxt = S_MUL;
				end else if (!sts.n_skip) begin
					st_nxt = S_NRD;
				end
			end
			S_NRD: begin
				cmd.rd_next = 1'b1;
				st_nxt      = S_NEV;
			end
			S_NEV: begin
				cmd.n_eval = 1'b1;
				if (sts.n_hit) begin
					st_nxt = S_MUL;
				end else begin
					st_nxt = S_NCHK;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				st_nxt  = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				st_nxt  = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					st_nxt       = S_IDLE;
				end
			end
			default: begin
				st_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end
endmodule

FILE: sv/bca_dpath.sv
// datapath: config, bitmap memory, divider, address build, response register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bca_dpath import bca_pkg::*; #(
	parameter int MAX_BLOCKS           = MAX_BLOCKS_DEF,
	parameter int CHUNKS_PER_BLOCK_MAX = CPB_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]            req_type,
	input  logic [ADDR_W-1:0]     req_address,
	input  bca_cmd_t              cmd,
	output bca_sts_t              sts,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [1:0]            rsp_status,
	output logic [ADDR_W-1:0]     rsp_chunk_address
);
	localparam int KW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int UW    = $clog2(MAX_BLOCKS + 1);
	localparam int NW    = $clog2(CHUNKS_PER_BLOCK_MAX) + 1;
	localparam int BPB   = (CHUNKS_PER_BLOCK_MAX + 7) / 8;
	localparam int BW    = (BPB > 1) ? $clog2(BPB) : 1;
	localparam int DEPTH = MAX_BLOCKS * BPB;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = NW + 4;
	localparam int DIV_N = ADDR_W;
	localparam int DCW   = $clog2(DIV_N);

	// configuration
	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] bsize_q;
	logic [SIZE_W-1:0] csize_q;
	logic [CPB_W-1:0]  cpb_q;

	// allocator state
	logic [UW-1:0] biu_q;
	logic [KW-1:0] active_q;
	logic [UW-1:0] cur_blk_q;
	logic [NW-1:0] cur_chunk_q;

	// request and scan registers
	logic [1:0]        rtype_q;
	logic [ADDR_W-1:0] raddr_q;
	logic [KW-1:0]     a_blk_q;
	logic [UW-1:0]     a_cnt_q;
	logic [BW-1:0]     a_byte_q;
	logic [BW-1:0]     clr_byte_q;

	// divider
	logic [ADDR_W-1:0] quo_q;
	logic [SIZE_W-1:0] rem_q;
	logic [DCW-1:0]    div_cnt_q;
	logic              div_ph_q;
	logic [ADDR_W-1:0] fblk_q;
	logic [NW-1:0]     f_ch_q;

	// result
	logic [1:0]            res_st_q;
	logic                  res_has_q;
	logic [KW-1:0]         res_blk_q;
	logic [NW-1:0]         res_ch_q;
	logic [KW+SIZE_W-1:0]  p_blk_q;
	logic [NW+SIZE_W-1:0]  p_ch_q;
	logic [ADDR_W-1:0]     sum_q;

	// bitmap memory
	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_addr_q;
	logic [AW-1:0]     mem_ra;
	logic              mem_re;
	logic [AW-1:0]     mem_wa;
	logic [BYTE_W-1:0] mem_wd;
	logic              mem_we;

	logic [NW-1:0]     n_eff;
	logic [BYTE_W-1:0] a_free;
	logic [2:0]        a_pos;
	logic              a_byte_last;
	logic              a_blk_last;
	logic [KW-1:0]     a_blk_nxt;
	logic [KW-1:0]     a_start;
	logic [BW-1:0]     n_byte;
	logic [BYTE_W-1:0] n_used;
	logic [2:0]        n_pos;
	logic [SIZE_W-1:0] divisor;
	logic [SIZE_W:0]   div_t;
	logic [ADDR_W-1:0] f_ch_full;

	function automatic logic [AW-1:0] mem_addr(input logic [KW-1:0] blk,
		input logic [BW-1:0] byt);
		return AW'(32'(blk) * BPB + 32'(byt));
	endfunction

	always_comb begin
		n_eff = (32'(cpb_q) > CHUNKS_PER_BLOCK_MAX) ? NW'(CHUNKS_PER_BLOCK_MAX) : NW'(cpb_q);
	end

	// allocate scan over one bitmap byte
	always_comb begin
		for (int p = 0; p < BYTE_W; p++) begin
			a_free[p] = !rd_data_q[p] && (EW'({a_byte_q, 3'(p)}) < EW'(n_eff));
		end
		a_pos       = low_bit8(a_free);
		a_byte_last = (EW'({a_byte_q, 3'b000}) + EW'(BYTE_W)) >= EW'(n_eff);
		a_blk_last  = (a_cnt_q + UW'(1)) == biu_q;
		a_blk_nxt   = ((UW'(a_blk_q) + UW'(1)) == biu_q) ? '0 : a_blk_q + KW'(1);
		a_start     = (UW'(active_q) < biu_q) ? active_q : '0;
	end

	// iteration over one bitmap byte from the cursor
	always_comb begin
		n_byte = BW'(cur_chunk_q >> 3);
		for (int p = 0; p < BYTE_W; p++) begin
			n_used[p] = rd_data_q[p] && (3'(p) >= cur_chunk_q[2:0]) &&
				(EW'({n_byte, 3'(p)}) < EW'(n_eff));
		end
		n_pos = low_bit8(n_used);
	end

	// restoring divide step
	always_comb begin
		divisor   = div_ph_q ? csize_q : bsize_q;
		div_t     = {rem_q, quo_q[ADDR_W-1]};
		f_ch_full = (csize_q == '0) ? '0 : quo_q;
	end

	always_comb begin
		sts           = '0;
		sts.req_type  = rtype_q;
		sts.n_zero    = n_eff == '0;
		sts.biu_zero  = biu_q == '0;
		sts.biu_full  = 32'(biu_q) >= MAX_BLOCKS;
		sts.free_bad  = (raddr_q < base_q) || (bsize_q == '0);
		sts.div_last  = div_cnt_q == DCW'(DIV_N - 1);
		sts.a_hit     = |a_free;
		sts.a_last    = a_byte_last && a_blk_last;
		sts.clr_last  = clr_byte_q == BW'(BPB - 1);
		sts.f_bad_blk = fblk_q >= ADDR_W'(biu_q);
		sts.f_skip    = f_ch_full >= ADDR_W'(n_eff);
		sts.n_end     = cur_blk_q >= biu_q;
		sts.n_skip    = cur_chunk_q >= n_eff;
		sts.n_hit     = |n_used;
		sts.out_free  = !rsp_valid || rsp_ready;
	end

	// memory port selection
	always_comb begin
		mem_re = cmd.rd_alloc || cmd.rd_free || cmd.rd_next;
		priority if (cmd.rd_alloc) begin
			mem_ra = mem_addr(a_blk_q, a_byte_q);
		end else if (cmd.rd_free) begin
			mem_ra = mem_addr(fblk_q[KW-1:0], BW'(f_ch_q >> 3));
		end else begin
			mem_ra = mem_addr(cur_blk_q[KW-1:0], n_byte);
		end
		mem_we = (cmd.a_eval && (|a_free)) || cmd.f_eval || cmd.clr_step;
		priority if (cmd.clr_step) begin
			mem_wa = mem_addr(KW'(biu_q), clr_byte_q);
			mem_wd = (clr_byte_q == '0) ? BYTE_W'(1) : '0;
		end else if (cmd.a_eval) begin
			mem_wa = rd_addr_q;
			mem_wd = rd_data_q | (BYTE_W'(1) << a_pos);
		end else begin
			mem_wa = rd_addr_q;
			mem_wd = rd_data_q & ~(BYTE_W'(1) << f_ch_q[2:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
			rd_addr_q <= mem_ra;
		end
	end

	// configuration and allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			bsize_q     <= BLOCK_SIZE_RST;
			csize_q     <= CHUNK_SIZE_RST;
			cpb_q       <= CPB_RST;
			biu_q       <= '0;
			active_q    <= '0;
			cur_blk_q   <= '0;
			cur_chunk_q <= '0;
			rsp_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_REGION_BASE:      base_q  <= cfg_data;
					CFG_BLOCK_SIZE:       bsize_q <= cfg_data[SIZE_W-1:0];
					CFG_CHUNK_SIZE:       csize_q <= cfg_data[SIZE_W-1:0];
					CFG_CHUNKS_PER_BLOCK: cpb_q   <= cfg_data[CPB_W-1:0];
				endcase
			end
			if (cmd.a_eval && (|a_free)) begin
				active_q <= a_blk_q;
			end
			if (cmd.clr_step && (clr_byte_q == BW'(BPB - 1))) begin
				biu_q    <= biu_q + UW'(1);
				active_q <= KW'(biu_q);
			end
			if (cmd.f_eval) begin
				active_q <= fblk_q[KW-1:0];
			end
			if (cmd.restart) begin
				cur_blk_q   <= '0;
				cur_chunk_q <= '0;
			end
			if (cmd.n_chk) begin
				if (cur_blk_q >= biu_q) begin
					cur_blk_q   <= '0;
					cur_chunk_q <= '0;
				end else if (cur_chunk_q >= n_eff) begin
					cur_chunk_q <= '0;
					cur_blk_q   <= cur_blk_q + UW'(1);
				end
			end
			if (cmd.n_eval) begin
				if (|n_used) begin
					cur_chunk_q <= NW'({n_byte, n_pos}) + NW'(1);
				end else begin
					cur_chunk_q <= NW'(EW'({n_byte, 3'b000}) + EW'(BYTE_W));
				end
			end
			if (cmd.out_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// request, scan, divider and result registers
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			rtype_q <= req_type;
			raddr_q <= req_address;
		end
		if (cmd.a_init) begin
			a_blk_q  <= a_start;
			a_cnt_q  <= '0;
			a_byte_q <= '0;
		end
		if (cmd.a_eval) begin
			if (|a_free) begin
				res_st_q  <= ST_OK;
				res_has_q <= 1'b1;
				res_blk_q <= a_blk_q;
				res_ch_q  <= NW'({a_byte_q, a_pos});
			end else if (!a_byte_last) begin
				a_byte_q <= a_byte_q + BW'(1);
			end else begin
				a_byte_q <= '0;
				a_blk_q  <= a_blk_nxt;
				a_cnt_q  <= a_cnt_q + UW'(1);
			end
		end
		if (cmd.clr_init) begin
			clr_byte_q <= '0;
		end
		if (cmd.clr_step) begin
			clr_byte_q <= clr_byte_q + BW'(1);
			res_st_q   <= ST_OK;
			res_has_q  <= 1'b1;
			res_blk_q  <= KW'(biu_q);
			res_ch_q   <= '0;
		end
		if (cmd.res_oom) begin
			res_st_q  <= ST_OOM;
			res_has_q <= 1'b0;
		end
		if (cmd.res_bad) begin
			res_st_q  <= ST_BAD_ADDR;
			res_has_q <= 1'b0;
		end
		if (cmd.restart) begin
			res_st_q  <= ST_OK;
			res_has_q <= 1'b0;
		end
		if (cmd.div_load1) begin
			quo_q     <= raddr_q - base_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
			div_ph_q  <= 1'b0;
		end
		if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DCW'(1);
			if (div_t >= {1'b0, divisor}) begin
				rem_q <= SIZE_W'(div_t - {1'b0, divisor});
				quo_q <= {quo_q[ADDR_W-2:0], 1'b1};
			end else begin
				rem_q <= div_t[SIZE_W-1:0];
				quo_q <= {quo_q[ADDR_W-2:0], 1'b0};
			end
		end
		if (cmd.div_mid) begin
			fblk_q    <= quo_q;
			quo_q     <= ADDR_W'(rem_q);
			rem_q     <= '0;
			div_cnt_q <= '0;
			div_ph_q  <= 1'b1;
		end
		if (cmd.f_chk) begin
			res_st_q  <= (fblk_q >= ADDR_W'(biu_q)) ? ST_BAD_ADDR : ST_OK;
			res_has_q <= 1'b0;
			f_ch_q    <= NW'(f_ch_full);
		end
		if (cmd.n_chk && (cur_blk_q >= biu_q)) begin
			res_st_q  <= ST_ITER_END;
			res_has_q <= 1'b0;
		end
		if (cmd.n_eval && (|n_used)) begin
			res_st_q  <= ST_OK;
			res_has_q <= 1'b1;
			res_blk_q <= cur_blk_q[KW-1:0];
			res_ch_q  <= NW'({n_byte, n_pos});
		end
		if (cmd.mul) begin
			p_blk_q <= res_blk_q * bsize_q;
			p_ch_q  <= res_ch_q * csize_q;
		end
		if (cmd.sum) begin
			sum_q <= base_q + ADDR_W'(p_blk_q) + ADDR_W'(p_ch_q);
		end
		if (cmd.out_load) begin
			rsp_status        <= res_st_q;
			rsp_chunk_address <= res_has_q ? sum_q : '0;
		end
	end

	`ASSERT_CLK(a_biu_bound, clk, arst_n, 32'(biu_q) <= MAX_BLOCKS)
	`ASSERT_CLK(a_active_in_use, clk, arst_n, (biu_q != '0) |-> (UW'(active_q) < biu_q))
	`ASSERT_NEVER(a_cursor_bound, clk, arst_n, cur_blk_q > biu_q)
endmodule

FILE: sv/bitmap_chunk_allocator.sv
// top level of the bitmap chunk allocator
// allocate scans bitmap bytes of the blocks in use, else joins and clears a new block
// free runs two 32-step divides, none below base; restart resets the iteration cursor
// next reads bitmap bytes from the cursor, block by block, up to the end of the pass
// one request in flight; a new one is taken the cycle after the response loads
// reset clears config to defaults and empties the pool; the bitmap needs no clearing pass
`timescale 1ns / 1ps
module bitmap_chunk_allocator import bca_pkg::*; #(
	parameter int MAX_BLOCKS           = MAX_BLOCKS_DEF,
	parameter int CHUNKS_PER_BLOCK_MAX = CPB_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bca_req_if.sink               req,
	bca_rsp_if.source             rsp
);
	// command and status between controller and datapath
	bca_cmd_t cmd;
	bca_sts_t sts;

	// sequencer: one state per memory access, divide loop or address step
	bca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// bitmap memory, divider, multipliers and the response register
	bca_dpath #(
		.MAX_BLOCKS           (MAX_BLOCKS),
		.CHUNKS_PER_BLOCK_MAX (CHUNKS_PER_BLOCK_MAX)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.req_type          (req.req_type),
		.req_address       (req.req_address),
		.cmd               (cmd),
		.sts               (sts),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_status        (rsp.status),
		.rsp_chunk_address (rsp.chunk_address)
	);
endmodule
